// File: src/ksc_pkg.sv
// shared types, constants and the record compare for the sort-and-count block
// no dependencies
package ksc_pkg;

  localparam int CAPACITY = 64;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  localparam logic [1:0] ST_ENTRY = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_DROP  = 2'd2;

  localparam logic [1:0] MODE_PLAIN  = 2'd0;
  localparam logic [1:0] MODE_VALUES = 2'd1;

  localparam logic [2:0] CFG_COUNT_MODE   = 3'd0;
  localparam logic [2:0] CFG_SUFFIX_WIDTH = 3'd1;
  localparam logic [2:0] CFG_VALUE_WIDTH  = 3'd2;
  localparam logic [2:0] CFG_LABEL_WIDTH  = 3'd3;

  typedef struct packed {
    logic [63:0] kh;
    logic [63:0] kl;
    logic [31:0] v;
    logic [63:0] lb;
  } ksc_rec_t;

  typedef struct packed {
    logic ins_en;
    logic pop;
  } ksc_ctl_t;

  typedef struct packed {
    ksc_rec_t head;
    ksc_rec_t second;
    logic     head_occ;
    logic     second_occ;
  } ksc_head_t;

  // field order of the struct gives suffix, then value, then label
  function automatic logic rec_less(input ksc_rec_t a, input ksc_rec_t b);
    rec_less = (a < b);
  endfunction

endpackage

// File: src/ksc_cell.sv
// one cell of the insertion chain: holds a record, inserts or shifts
// depends on ksc_pkg
module ksc_cell (
  input  logic              clk,
  input  ksc_pkg::ksc_ctl_t ctl,
  input  ksc_pkg::ksc_rec_t ins_rec,
  input  ksc_pkg::ksc_rec_t left_rec,
  input  logic              left_less,
  input  logic              left_occ,
  input  ksc_pkg::ksc_rec_t right_rec,
  input  logic              occ,
  output ksc_pkg::ksc_rec_t rec,
  output logic              less
);

  assign less = occ && ksc_pkg::rec_less(ins_rec, rec);

  always_ff @(posedge clk) begin
    if (ctl.pop) begin
      rec <= right_rec;
    end else if (ctl.ins_en) begin
      if (left_less) begin
        rec <= left_rec;
      end else if (less || (!occ && left_occ)) begin
        rec <= ins_rec;
      end
    end
  end

endmodule

// File: src/ksc_chain.sv
// row of insertion cells kept in ascending order, with fill count
// depends on ksc_pkg and ksc_cell
module ksc_chain (
  input  logic                     clk,
  input  logic                     rst,
  input  ksc_pkg::ksc_ctl_t        ctl,
  input  ksc_pkg::ksc_rec_t        ins_rec,
  output ksc_pkg::ksc_head_t       hd,
  output logic [ksc_pkg::CNT_W-1:0] filled
);

  ksc_pkg::ksc_rec_t recs [ksc_pkg::CAPACITY];
  logic              less [ksc_pkg::CAPACITY];
  logic              occ  [ksc_pkg::CAPACITY];

  genvar i;
  generate
    for (i = 0; i < ksc_pkg::CAPACITY; i++) begin : g_cell
      ksc_pkg::ksc_rec_t left_rec;
      ksc_pkg::ksc_rec_t right_rec;
      logic              left_less;
      logic              left_occ;

      assign occ[i] = (ksc_pkg::CNT_W'(i) < filled);

      if (i == 0) begin : g_first
        assign left_rec  = recs[0];
        assign left_less = 1'b0;
        assign left_occ  = 1'b1;
      end else begin : g_inner
        assign left_rec  = recs[i-1];
        assign left_less = less[i-1];
        assign left_occ  = occ[i-1];
      end

      if (i == ksc_pkg::CAPACITY - 1) begin : g_tail
        assign right_rec = recs[i];
      end else begin : g_mid
        assign right_rec = recs[i+1];
      end

      ksc_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .ins_rec   (ins_rec),
        .left_rec  (left_rec),
        .left_less (left_less),
        .left_occ  (left_occ),
        .right_rec (right_rec),
        .occ       (occ[i]),
        .rec       (recs[i]),
        .less      (less[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= '0;
    end else if (ctl.pop) begin
      filled <= filled - ksc_pkg::CNT_W'(1);
    end else if (ctl.ins_en) begin
      filled <= filled + ksc_pkg::CNT_W'(1);
    end
  end

  assign hd.head       = recs[0];
  assign hd.second     = recs[1];
  assign hd.head_occ   = occ[0];
  assign hd.second_occ = occ[1];

endmodule

// File: src/ksc_emit.sv
// run accumulator over popped records and the result register
// depends on ksc_pkg
module ksc_emit (
  input  logic               clk,
  input  logic               rst,
  input  logic               pop,
  input  ksc_pkg::ksc_head_t hd,
  input  logic [1:0]         mode,
  input  logic               inj_valid,
  input  logic [1:0]         inj_status,
  input  logic               out_stall,
  output logic               out_free,
  output logic               out_valid,
  output logic [63:0]        key_high,
  output logic [63:0]        key_low,
  output logic [31:0]        tally,
  output logic [63:0]        label_sum,
  output logic [1:0]         status,
  output logic               last
);

  logic        acc_valid;
  logic [31:0] acc_t;
  logic [63:0] acc_ls;
  logic [31:0] t_next;
  logic [63:0] ls_next;
  logic        boundary;
  logic        multiset;

  assign out_free = !out_valid || !out_stall;
  assign multiset = (mode != ksc_pkg::MODE_PLAIN) && (mode != ksc_pkg::MODE_VALUES);
  assign boundary = !hd.second_occ || (hd.second.kh != hd.head.kh) ||
                    (hd.second.kl != hd.head.kl);

  always_comb begin
    t_next  = acc_valid ? acc_t : 32'd0;
    ls_next = acc_valid ? acc_ls : 64'd0;
    if (mode == ksc_pkg::MODE_PLAIN) begin
      t_next = t_next + 32'd1;
    end else begin
      t_next  = t_next + hd.head.v;
      ls_next = ls_next + hd.head.lb;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      acc_valid <= 1'b0;
    end else if (inj_valid) begin
      out_valid <= 1'b1;
      key_high  <= '0;
      key_low   <= '0;
      tally     <= '0;
      label_sum <= '0;
      status    <= inj_status;
      last      <= 1'b1;
    end else if (pop) begin
      if (multiset) begin
        out_valid <= 1'b1;
        key_high  <= hd.head.kh;
        key_low   <= hd.head.kl;
        tally     <= hd.head.v;
        label_sum <= '0;
        status    <= ksc_pkg::ST_ENTRY;
        last      <= !hd.second_occ;
      end else if (boundary) begin
        out_valid <= 1'b1;
        key_high  <= hd.head.kh;
        key_low   <= hd.head.kl;
        tally     <= t_next;
        label_sum <= ls_next;
        status    <= ksc_pkg::ST_ENTRY;
        last      <= !hd.second_occ;
        acc_valid <= 1'b0;
      end else begin
        out_valid <= 1'b0;
        acc_t     <= t_next;
        acc_ls    <= ls_next;
        acc_valid <= 1'b1;
      end
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// File: src/kmer_sort_and_count.sv
// top level of the sort-and-count store: config registers, load masking, control
// depends on ksc_pkg, ksc_chain and ksc_emit
//
// Input items carry an operation: load puts one record into a sorted chain
// of CAPACITY cells, flush sends out the sorted contents and empties it.
// Loads are taken one per cycle; each enters a staging register and is
// inserted into the chain in the next cycle, all cells comparing at once.
// A load into a full store gives one result with status drop; a flush of an
// empty store gives one result with status empty, registered on accept.
// In a flush the chain shifts one record per cycle toward its head, where
// a run accumulator emits at most one result per cycle; inputs are stalled
// until the last record has left. The result register holds while
// out_stall is high; pops, flushes and loads into a full store wait for
// it, other loads go on. Config writes use cfg_valid/cfg_ready (always
// ready) and must be made by the user while the block is idle; the block
// does not enforce this. Reset empties the store and restores register
// defaults: plain mode, 64 suffix bits, full values, zero labels.
module kmer_sort_and_count (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        operation,
  input  logic [63:0] suffix_high,
  input  logic [63:0] suffix_low,
  input  logic [31:0] entry_value,
  input  logic [63:0] entry_label,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] key_high,
  output logic [63:0] key_low,
  output logic [31:0] tally,
  output logic [63:0] label_sum,
  output logic [1:0]  status,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  typedef enum logic {IDLE, FLUSH} state_t;

  state_t                    state;
  logic [1:0]                count_mode;
  logic [7:0]                suffix_width;
  logic [5:0]                value_width;
  logic [6:0]                label_width;
  logic [ksc_pkg::CNT_W-1:0] record_count;
  logic [ksc_pkg::CNT_W-1:0] filled;
  logic                      pend_valid;
  ksc_pkg::ksc_rec_t         pend_rec;
  ksc_pkg::ksc_rec_t         masked;
  ksc_pkg::ksc_ctl_t         ctl;
  ksc_pkg::ksc_head_t        hd;
  logic                      out_free;
  logic                      accept;
  logic                      pop;
  logic                      inj_valid;
  logic [1:0]                inj_status;
  logic [7:0]                sw;
  logic [127:0]              key_mask;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state == FLUSH) ||
                     (!out_free && (operation ||
                      record_count == ksc_pkg::CNT_W'(ksc_pkg::CAPACITY)));
  assign accept    = in_valid && !in_stall;
  assign pop       = (state == FLUSH) && !pend_valid && hd.head_occ && out_free;
  assign ctl.pop   = pop;
  assign ctl.ins_en = pend_valid;

  always_comb begin
    sw        = (suffix_width == 8'd0) ? 8'd1 : suffix_width;
    key_mask  = ~({128{1'b1}} << sw);
    masked.kh = suffix_high & key_mask[127:64];
    masked.kl = suffix_low & key_mask[63:0];
    masked.v  = (value_width == 6'd0) ? entry_value :
                (entry_value & ~(32'hFFFF_FFFF << value_width));
    masked.lb = (label_width == 7'd0) ? 64'd0 :
                (entry_label & ~({64{1'b1}} << label_width));
  end

  always_comb begin
    inj_valid  = 1'b0;
    inj_status = ksc_pkg::ST_ENTRY;
    if (accept) begin
      if (!operation && record_count == ksc_pkg::CNT_W'(ksc_pkg::CAPACITY)) begin
        inj_valid  = 1'b1;
        inj_status = ksc_pkg::ST_DROP;
      end else if (operation && record_count == '0) begin
        inj_valid  = 1'b1;
        inj_status = ksc_pkg::ST_EMPTY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_mode   <= ksc_pkg::MODE_PLAIN;
      suffix_width <= 8'd64;
      value_width  <= 6'd0;
      label_width  <= 7'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ksc_pkg::CFG_COUNT_MODE:   count_mode   <= cfg_data[1:0];
        ksc_pkg::CFG_SUFFIX_WIDTH: suffix_width <= cfg_data;
        ksc_pkg::CFG_VALUE_WIDTH:  value_width  <= cfg_data[5:0];
        ksc_pkg::CFG_LABEL_WIDTH:  label_width  <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      record_count <= '0;
      pend_valid   <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          pend_valid <= accept && !inj_valid && !operation;
          if (accept && !inj_valid) begin
            if (operation) begin
              state <= FLUSH;
            end else begin
              pend_rec     <= masked;
              record_count <= record_count + ksc_pkg::CNT_W'(1);
            end
          end
        end
        FLUSH: begin
          pend_valid <= 1'b0;
          if (pop && !hd.second_occ) begin
            state        <= IDLE;
            record_count <= '0;
          end
        end
        default: begin
          state      <= IDLE;
          pend_valid <= 1'b0;
        end
      endcase
    end
  end

  ksc_chain u_chain (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .ins_rec (pend_rec),
    .hd      (hd),
    .filled  (filled)
  );

  ksc_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .pop        (pop),
    .hd         (hd),
    .mode       (count_mode),
    .inj_valid  (inj_valid),
    .inj_status (inj_status),
    .out_stall  (out_stall),
    .out_free   (out_free),
    .out_valid  (out_valid),
    .key_high   (key_high),
    .key_low    (key_low),
    .tally      (tally),
    .label_sum  (label_sum),
    .status     (status),
    .last       (last)
  );

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    record_count <= ksc_pkg::CNT_W'(ksc_pkg::CAPACITY))
    else $error("record count above capacity");

  a_fill_match : assert property (@(posedge clk) disable iff (rst)
    (state == IDLE) |->
      (ksc_pkg::CNT_W'(filled + ksc_pkg::CNT_W'(pend_valid)) == record_count))
    else $error("chain fill out of step with record count");

  a_flush_end : assert property (@(posedge clk) disable iff (rst)
    (pop && !hd.second_occ) |=> (state == IDLE && filled == '0 && out_valid && last))
    else $error("flush did not end with a last item and an empty chain");

  a_status_last : assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ksc_pkg::ST_ENTRY) |-> last)
    else $error("status item without last");

endmodule

// File: tb/sv/tb_kmer_sort_and_count.sv
// testbench for kmer_sort_and_count: loads records, flushes them in every count mode
// and checks each result against an in-bench sorted store; depends on ksc_pkg and the rtl
`timescale 1ns / 100ps

module tb_kmer_sort_and_count;

  localparam logic       OP_LOAD       = 1'b0;
  localparam logic       OP_FLUSH      = 1'b1;
  localparam logic [1:0] MODE_MULTISET = 2'd2;
  localparam logic [1:0] MODE_SPARE    = 2'd3;
  localparam int RANDOM_ITEMS  = 100;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 2000;
  localparam int REPORT_LIMIT  = 10;

  typedef struct packed {
    logic        op;
    logic [63:0] sh;
    logic [63:0] sl;
    logic [31:0] v;
    logic [63:0] lb;
  } item_t;

  typedef struct packed {
    logic [63:0] kh;
    logic [63:0] kl;
    logic [31:0] v;
    logic [63:0] lb;
  } record_t;

  typedef struct packed {
    logic [63:0] kh;
    logic [63:0] kl;
    logic [31:0] tally;
    logic [63:0] ls;
    logic [1:0]  status;
    logic        last;
  } tally_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        operation = 1'b0;
  logic [63:0] suffix_high = '0;
  logic [63:0] suffix_low = '0;
  logic [31:0] entry_value = '0;
  logic [63:0] entry_label = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] key_high;
  logic [63:0] key_low;
  logic [31:0] tally;
  logic [63:0] label_sum;
  logic [1:0]  status;
  logic        last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;

  kmer_sort_and_count dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .suffix_high(suffix_high), .suffix_low(suffix_low),
    .entry_value(entry_value), .entry_label(entry_label),
    .out_valid(out_valid), .out_stall(out_stall),
    .key_high(key_high), .key_low(key_low), .tally(tally), .label_sum(label_sum),
    .status(status), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // shadow registers, reset values
  logic [1:0] count_mode   = ksc_pkg::MODE_PLAIN;
  logic [7:0] suffix_width = 8'd64;
  logic [5:0] value_width  = 6'd0;
  logic [6:0] label_width  = 7'd0;

  item_t   pending_items[$];
  record_t stored_records[$];
  tally_t  expected_results[$];
  item_t   cur_item;

  bit quiet_run = 1'b0;
  int gap_left = 0;
  int stall_left = 0;
  int stuck_cycles = 0;
  int n_queued = 0;
  int n_accepted = 0;
  int n_random = 0;
  int n_flushes = 0;
  int n_empty = 0;
  int n_drops = 0;
  int n_checked = 0;
  int n_cfg = 0;
  int n_mismatches = 0;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic bit rec_precedes(input record_t a, input record_t b);
    if (a.kh != b.kh) return a.kh < b.kh;
    if (a.kl != b.kl) return a.kl < b.kl;
    if (a.v != b.v) return a.v < b.v;
    return a.lb < b.lb;
  endfunction

  task automatic push_status(input logic [1:0] st);
    tally_t r;
    r = '0;
    r.status = st;
    r.last = 1'b1;
    expected_results.push_back(r);
  endtask

  task automatic insert_record(input item_t it);
    logic [7:0]   sw;
    logic [127:0] key;
    record_t      r;
    int           pos;
    sw = suffix_width;
    if (sw == 8'd0) sw = 8'd1;
    if (sw > 8'd128) sw = 8'd128;
    key = {it.sh, it.sl};
    if (sw < 8'd128) key = key & ((128'd1 << sw) - 128'd1);
    r.kh = key[127:64];
    r.kl = key[63:0];
    r.v = it.v;
    if (value_width != 6'd0 && value_width < 6'd32)
      r.v = it.v & ((32'd1 << value_width) - 32'd1);
    if (label_width == 7'd0) r.lb = '0;
    else if (label_width < 7'd64) r.lb = it.lb & ((64'd1 << label_width) - 64'd1);
    else r.lb = it.lb;
    pos = stored_records.size();
    while (pos > 0 && rec_precedes(r, stored_records[pos-1])) pos--;
    stored_records.insert(pos, r);
  endtask

  task automatic emit_sorted();
    logic [1:0] m;
    tally_t     r;
    m = count_mode;
    if (m == ksc_pkg::MODE_PLAIN || m == ksc_pkg::MODE_VALUES) begin
      r = '0;
      r.kh = stored_records[0].kh;
      r.kl = stored_records[0].kl;
      r.tally = (m == ksc_pkg::MODE_PLAIN) ? 32'd1 : stored_records[0].v;
      r.ls = (m == ksc_pkg::MODE_PLAIN) ? 64'd0 : stored_records[0].lb;
      for (int i = 1; i < stored_records.size(); i++) begin
        if (stored_records[i].kh != r.kh || stored_records[i].kl != r.kl) begin
          expected_results.push_back(r);
          r.kh = stored_records[i].kh;
          r.kl = stored_records[i].kl;
          r.tally = '0;
          r.ls = '0;
        end
        if (m == ksc_pkg::MODE_PLAIN) begin
          r.tally = r.tally + 32'd1;
        end else begin
          r.tally = r.tally + stored_records[i].v;
          r.ls = r.ls + stored_records[i].lb;
        end
      end
      expected_results.push_back(r);
    end else begin
      foreach (stored_records[i]) begin
        r = '0;
        r.kh = stored_records[i].kh;
        r.kl = stored_records[i].kl;
        r.tally = stored_records[i].v;
        r.status = ksc_pkg::ST_ENTRY;
        expected_results.push_back(r);
      end
    end
    expected_results[expected_results.size()-1].last = 1'b1;
    stored_records.delete();
  endtask

  task automatic predict_item(input item_t it);
    if (it.op == OP_LOAD) begin
      if (stored_records.size() >= ksc_pkg::CAPACITY) begin
        push_status(ksc_pkg::ST_DROP);
        n_drops++;
      end else begin
        insert_record(it);
      end
    end else begin
      n_flushes++;
      if (stored_records.size() == 0) begin
        push_status(ksc_pkg::ST_EMPTY);
        n_empty++;
      end else begin
        emit_sorted();
      end
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_item(cur_item);
        n_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          cur_item = pending_items.pop_front();
          operation <= cur_item.op;
          suffix_high <= cur_item.sh;
          suffix_low <= cur_item.sl;
          entry_value <= cur_item.v;
          entry_label <= cur_item.lb;
          in_valid <= 1'b1;
          if (!quiet_run && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 10);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    tally_t got;
    tally_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{kh: key_high, kl: key_low, tally: tally, ls: label_sum,
                status: status, last: last};
        n_checked++;
        if (expected_results.size() == 0) begin
          n_mismatches++;
          if (n_mismatches <= REPORT_LIMIT)
            $display("unexpected result: key %h_%h tally %h labels %h status %0d last %b",
                     got.kh, got.kl, got.tally, got.ls, got.status, got.last);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            n_mismatches++;
            if (n_mismatches <= REPORT_LIMIT) begin
              $display("mismatch: expected key %h_%h tally %h labels %h status %0d last %b",
                       want.kh, want.kl, want.tally, want.ls, want.status, want.last);
              $display("          got      key %h_%h tally %h labels %h status %0d last %b",
                       got.kh, got.kl, got.tally, got.ls, got.status, got.last);
            end
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (!quiet_run && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 10);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      stuck_cycles = 0;
    else
      stuck_cycles++;
    if (stuck_cycles >= STALL_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles, %0d results outstanding",
               STALL_LIMIT, expected_results.size());
      $display("tb_kmer_sort_and_count: FAIL");
      $finish;
    end
  end

  task automatic queue_item(input logic op, input logic [63:0] sh, input logic [63:0] sl,
                            input logic [31:0] v, input logic [63:0] lb);
    pending_items.push_back('{op: op, sh: sh, sl: sl, v: v, lb: lb});
    n_queued++;
  endtask

  task automatic wait_idle();
    while (!(n_accepted == n_queued && expected_results.size() == 0)) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // leaves cfg_valid high so back-to-back writes need one assignment per edge
  task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    n_cfg++;
    case (idx)
      ksc_pkg::CFG_COUNT_MODE:   count_mode = data[1:0];
      ksc_pkg::CFG_SUFFIX_WIDTH: suffix_width = data;
      ksc_pkg::CFG_VALUE_WIDTH:  value_width = data[5:0];
      ksc_pkg::CFG_LABEL_WIDTH:  label_width = data[6:0];
      default: ;
    endcase
  endtask

  task automatic random_config();
    logic [7:0] sw;
    logic [5:0] vw;
    logic [6:0] lw;
    case ($urandom_range(0, 7))
      0: sw = 8'd1;
      1: sw = 8'd0;
      2: sw = 8'd64;
      3: sw = 8'd65;
      4: sw = 8'd128;
      5: sw = 8'd255;
      default: sw = 8'($urandom_range(1, 128));
    endcase
    case ($urandom_range(0, 4))
      0: vw = 6'd0;
      1: vw = 6'd1;
      2: vw = 6'd32;
      3: vw = 6'd63;
      default: vw = 6'($urandom_range(0, 63));
    endcase
    case ($urandom_range(0, 4))
      0: lw = 7'd0;
      1: lw = 7'd1;
      2: lw = 7'd64;
      3: lw = 7'd127;
      default: lw = 7'($urandom_range(0, 127));
    endcase
    write_reg(ksc_pkg::CFG_COUNT_MODE, {6'($urandom), 2'($urandom_range(0, 3))});
    write_reg(ksc_pkg::CFG_SUFFIX_WIDTH, sw);
    write_reg(ksc_pkg::CFG_VALUE_WIDTH, {2'($urandom), vw});
    write_reg(ksc_pkg::CFG_LABEL_WIDTH, {1'($urandom), lw});
    if ($urandom_range(0, 3) == 0)
      write_reg(ksc_pkg::CFG_LABEL_WIDTH + 3'($urandom_range(1, 4)), 8'($urandom));
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [63:0] pool_hi[4];
    logic [63:0] pool_lo[4];
    logic [63:0] sh;
    logic [63:0] sl;
    logic [31:0] v;
    int          n_loads;
    int          k;
    bit          overflow_done;

    overflow_done = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset defaults: plain counts, 64 suffix bits, labels forced to zero
    queue_item(OP_FLUSH, rand64(), rand64(), $urandom, rand64());
    queue_item(OP_LOAD, '1, '1, '1, '1);
    queue_item(OP_LOAD, '0, '0, '0, '0);
    queue_item(OP_LOAD, '1, '1, '1, '1);
    queue_item(OP_LOAD, 64'd1, 64'd5, $urandom, rand64());
    queue_item(OP_FLUSH, rand64(), rand64(), $urandom, rand64());
    wait_idle();

    // value and label sums that wrap, full 128-bit keys
    write_reg(ksc_pkg::CFG_COUNT_MODE, {6'd0, ksc_pkg::MODE_VALUES});
    write_reg(ksc_pkg::CFG_SUFFIX_WIDTH, 8'd128);
    write_reg(ksc_pkg::CFG_LABEL_WIDTH, 8'd64);
    cfg_valid <= 1'b0;
    queue_item(OP_LOAD, '1, '1, '1, '1);
    queue_item(OP_LOAD, '1, '1, '1, '1);
    queue_item(OP_LOAD, '0, '0, '0, '0);
    queue_item(OP_LOAD, '1, '1, 32'd1, 64'd1);
    queue_item(OP_FLUSH, '1, '1, '1, '1);
    queue_item(OP_FLUSH, '0, '0, '0, '0);
    wait_idle();

    // multiset with one-bit widths
    write_reg(ksc_pkg::CFG_COUNT_MODE, {6'd0, MODE_MULTISET});
    write_reg(ksc_pkg::CFG_SUFFIX_WIDTH, 8'd1);
    write_reg(ksc_pkg::CFG_VALUE_WIDTH, 8'd1);
    write_reg(ksc_pkg::CFG_LABEL_WIDTH, 8'd1);
    cfg_valid <= 1'b0;
    repeat (3) queue_item(OP_LOAD, rand64(), rand64(), $urandom, rand64());
    queue_item(OP_FLUSH, rand64(), rand64(), $urandom, rand64());
    wait_idle();

    // out-of-range register values saturate, unused index ignored
    write_reg(ksc_pkg::CFG_COUNT_MODE, {6'd0, MODE_SPARE});
    write_reg(ksc_pkg::CFG_SUFFIX_WIDTH, 8'd255);
    write_reg(ksc_pkg::CFG_VALUE_WIDTH, 8'd63);
    write_reg(ksc_pkg::CFG_LABEL_WIDTH, 8'd127);
    write_reg(ksc_pkg::CFG_LABEL_WIDTH + 3'd1, 8'hff);
    cfg_valid <= 1'b0;
    queue_item(OP_LOAD, '1, '1, '1, '1);
    queue_item(OP_LOAD, rand64(), rand64(), $urandom, rand64());
    queue_item(OP_FLUSH, rand64(), rand64(), $urandom, rand64());
    wait_idle();

    // random phases: config, at times an empty flush, a batch of loads with repeated keys, then a flush
    while (n_random < RANDOM_ITEMS) begin
      random_config();
      if (n_random >= RANDOM_ITEMS - 40) quiet_run = 1'b1;
      else quiet_run = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < 4; i++) begin
        pool_hi[i] = rand64();
        pool_lo[i] = rand64();
      end
      if (!overflow_done && n_random > 30) begin
        n_loads = ksc_pkg::CAPACITY + $urandom_range(1, 3);
        overflow_done = 1'b1;
      end else begin
        n_loads = $urandom_range(1, 12);
      end
      if ($urandom_range(0, 5) == 0) begin
        queue_item(OP_FLUSH, rand64(), rand64(), $urandom, rand64());
        n_random++;
      end
      for (int j = 0; j < n_loads; j++) begin
        if ($urandom_range(0, 9) < 6) begin
          k = $urandom_range(0, 3);
          sh = pool_hi[k];
          sl = pool_lo[k];
        end else begin
          sh = rand64();
          sl = rand64();
        end
        case ($urandom_range(0, 3))
          0: v = '0;
          1: v = '1;
          default: v = $urandom;
        endcase
        queue_item(OP_LOAD, sh, sl, v, rand64());
      end
      queue_item(OP_FLUSH, rand64(), rand64(), $urandom, rand64());
      n_random += n_loads + 1;
      wait_idle();
    end

    repeat (20) @(posedge clk);
    $display("run covered %0d items in %0d flushes, %0d results checked, %0d config writes",
             n_accepted, n_flushes, n_checked, n_cfg);
    $display("empty flushes %0d, dropped records %0d, mismatches %0d",
             n_empty, n_drops, n_mismatches);
    if (n_mismatches == 0 && expected_results.size() == 0)
      $display("tb_kmer_sort_and_count: PASS");
    else
      $display("tb_kmer_sort_and_count: FAIL");
    $finish;
  end

endmodule
